// ===== rtl/rgd_pkg.sv =====
// rgd_pkg: shared types and constants for the rectangle gap distance block.
// No dependencies.
package rgd_pkg;

  // Result field width, fixed by the output format.
  localparam int OUT_W = 15;

  // Separation of B relative to A, one bit per side.
  typedef struct packed {
    logic left;
    logic right;
    logic below;
    logic above;
  } sep_flags_t;

endpackage

// ===== rtl/rgd_in_if.sv =====
// rgd_in_if: valid/ready channel that carries one rectangle pair.
// rgd_out_if: valid/ready channel that carries one gap distance.
// rgd_in_if width set by COORD_BITS; rgd_out_if takes OUT_W from rgd_pkg.
interface rgd_in_if #(
  parameter int COORD_BITS = 13
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] a_left;
  logic [COORD_BITS-1:0] a_low;
  logic [COORD_BITS-1:0] a_width;
  logic [COORD_BITS-1:0] a_height;
  logic [COORD_BITS-1:0] b_left;
  logic [COORD_BITS-1:0] b_low;
  logic [COORD_BITS-1:0] b_width;
  logic [COORD_BITS-1:0] b_height;

  modport source (
    output valid, a_left, a_low, a_width, a_height, b_left, b_low, b_width, b_height,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_low, a_width, a_height, b_left, b_low, b_width, b_height,
    output ready
  );
endinterface

// rgd_out_if: valid/ready channel that carries one gap distance.
interface rgd_out_if import rgd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] gap_distance;

  modport source (output valid, gap_distance, input ready);
  modport sink (input valid, gap_distance, output ready);
endinterface

// ===== rtl/rect_gap_distance.sv =====
// rect_gap_distance: gap distance between two axis-aligned rectangles.
// Throughput: one item per cycle while the output is not stalled; the square root resolves one root bit per stage.
// Each stage has its own valid bit and load enable, so bubbles collapse on a stall.
// Reset (rst_n low, synchronous) empties every stage; payload registers are not reset.
// Depends on rgd_pkg, rgd_in_if, rgd_out_if.
module rect_gap_distance import rgd_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic      clk,
  input  logic      rst_n,
  rgd_in_if.sink    in_ch,
  rgd_out_if.source out_ch
);

  localparam int CW    = COORD_BITS;
  localparam int EW    = CW + 1;            // far edge, never wraps
  localparam int SQ_W  = 2 * CW;            // one square
  localparam int RES_W = CW + 1;            // root bits
  localparam int RAD_W = 2 * RES_W;         // radicand, even width
  localparam int REM_W = RES_W + 2;         // partial remainder
  localparam int EXT_W = (RES_W > OUT_W) ? RES_W : OUT_W;
  localparam int NF    = 5;                 // stages ahead of the root
  localparam int NSTG  = NF + RES_W + 1;    // plus the output register

  // ---------------------------------------------------------------------------
  // Stage control. A stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   en;

  assign en[NSTG] = out_ch.ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  assign vld_in = {vld_r[NSTG-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (vld_r & ~en[NSTG-1:0]) | (vld_in & en[NSTG-1:0]);
    end
  end

  assign in_ch.ready = en[0];

  // ---------------------------------------------------------------------------
  // Stage 1: register origins and form far edges.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s1_ax0_r, s1_ay0_r, s1_bx0_r, s1_by0_r;
  logic [EW-1:0] s1_ax1_r, s1_ay1_r, s1_bx1_r, s1_by1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ax0_r <= in_ch.a_left;
      s1_ay0_r <= in_ch.a_low;
      s1_bx0_r <= in_ch.b_left;
      s1_by0_r <= in_ch.b_low;
      s1_ax1_r <= EW'(in_ch.a_left) + EW'(in_ch.a_width);
      s1_ay1_r <= EW'(in_ch.a_low)  + EW'(in_ch.a_height);
      s1_bx1_r <= EW'(in_ch.b_left) + EW'(in_ch.b_width);
      s1_by1_r <= EW'(in_ch.b_low)  + EW'(in_ch.b_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: separation flags and the four candidate gaps, in parallel.
  // A gap is only meaningful when its flag is set; then it fits in CW bits.
  // ---------------------------------------------------------------------------
  sep_flags_t    flags_nxt;
  logic [CW-1:0] gap_l_nxt, gap_r_nxt, gap_b_nxt, gap_a_nxt;

  assign flags_nxt.left  = s1_bx1_r < EW'(s1_ax0_r);
  assign flags_nxt.right = s1_ax1_r < EW'(s1_bx0_r);
  assign flags_nxt.below = s1_by1_r < EW'(s1_ay0_r);
  assign flags_nxt.above = s1_ay1_r < EW'(s1_by0_r);

  assign gap_l_nxt = CW'(EW'(s1_ax0_r) - s1_bx1_r);
  assign gap_r_nxt = CW'(EW'(s1_bx0_r) - s1_ax1_r);
  assign gap_b_nxt = CW'(EW'(s1_ay0_r) - s1_by1_r);
  assign gap_a_nxt = CW'(EW'(s1_by0_r) - s1_ay1_r);

  sep_flags_t    s2_flags_r;
  logic [CW-1:0] s2_gap_l_r, s2_gap_r_r, s2_gap_b_r, s2_gap_a_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_flags_r <= flags_nxt;
      s2_gap_l_r <= gap_l_nxt;
      s2_gap_r_r <= gap_r_nxt;
      s2_gap_b_r <= gap_b_nxt;
      s2_gap_a_r <= gap_a_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pick the corner deltas and the single-axis gap.
  // Left/right and below/above are mutually exclusive, so the diagonal
  // priority order collapses to one x pick and one y pick.
  // ---------------------------------------------------------------------------
  logic          diag_nxt;
  logic [CW-1:0] dx_nxt, dy_nxt, axis_nxt;

  assign diag_nxt = (s2_flags_r.left | s2_flags_r.right) &
                    (s2_flags_r.below | s2_flags_r.above);
  assign dx_nxt   = s2_flags_r.left  ? s2_gap_l_r : s2_gap_r_r;
  assign dy_nxt   = s2_flags_r.below ? s2_gap_b_r : s2_gap_a_r;

  always_comb begin
    if (s2_flags_r.left) begin
      axis_nxt = s2_gap_l_r;
    end else if (s2_flags_r.right) begin
      axis_nxt = s2_gap_r_r;
    end else if (s2_flags_r.below) begin
      axis_nxt = s2_gap_b_r;
    end else if (s2_flags_r.above) begin
      axis_nxt = s2_gap_a_r;
    end else begin
      axis_nxt = '0;          // overlap or touch
    end
  end

  logic          s3_diag_r;
  logic [CW-1:0] s3_dx_r, s3_dy_r, s3_axis_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_diag_r <= diag_nxt;
      s3_dx_r   <= dx_nxt;
      s3_dy_r   <= dy_nxt;
      s3_axis_r <= axis_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squares. Stage 5: sum into the radicand.
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] sqx_nxt, sqy_nxt;
  assign sqx_nxt = SQ_W'(s3_dx_r) * SQ_W'(s3_dx_r);
  assign sqy_nxt = SQ_W'(s3_dy_r) * SQ_W'(s3_dy_r);

  logic            s4_diag_r;
  logic [CW-1:0]   s4_axis_r;
  logic [SQ_W-1:0] s4_sqx_r, s4_sqy_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_diag_r <= s3_diag_r;
      s4_axis_r <= s3_axis_r;
      s4_sqx_r  <= sqx_nxt;
      s4_sqy_r  <= sqy_nxt;
    end
  end

  logic             s5_diag_r;
  logic [CW-1:0]    s5_axis_r;
  logic [RAD_W-1:0] s5_rad_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_diag_r <= s4_diag_r;
      s5_axis_r <= s4_axis_r;
      s5_rad_r  <= RAD_W'(s4_sqx_r) + RAD_W'(s4_sqy_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Floor square root, restoring digit recurrence: one root bit per stage.
  // Each stage pulls the top two radicand bits into the remainder and tries
  // subtracting (root << 2) | 1.
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0] rt_rem_r  [RES_W];
  logic [RES_W-1:0] rt_root_r [RES_W];
  logic [RAD_W-1:0] rt_rad_r  [RES_W];
  logic             rt_diag_r [RES_W];
  logic [CW-1:0]    rt_axis_r [RES_W];

  for (genvar j = 0; j < RES_W; j++) begin : g_root
    logic [REM_W-1:0] rem_in, cur, trial, rem_nxt;
    logic [RES_W-1:0] root_in, root_nxt;
    logic [RAD_W-1:0] rad_in;
    logic             diag_in;
    logic [CW-1:0]    axis_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = s5_rad_r;
      assign diag_in = s5_diag_r;
      assign axis_in = s5_axis_r;
    end else begin : g_next
      assign rem_in  = rt_rem_r[j-1];
      assign root_in = rt_root_r[j-1];
      assign rad_in  = rt_rad_r[j-1];
      assign diag_in = rt_diag_r[j-1];
      assign axis_in = rt_axis_r[j-1];
    end

    assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_in[RES_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_in[RES_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en[NF+j]) begin
        rt_rem_r[j]  <= rem_nxt;
        rt_root_r[j] <= root_nxt;
        rt_rad_r[j]  <= rad_in << 2;
        rt_diag_r[j] <= diag_in;
        rt_axis_r[j] <= axis_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: root for a diagonal case, else the axis gap.
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0] root_ext, axis_ext;
  logic [OUT_W-1:0] dist_nxt, out_dist_r;

  assign root_ext = EXT_W'(rt_root_r[RES_W-1]);
  assign axis_ext = EXT_W'(rt_axis_r[RES_W-1]);
  assign dist_nxt = rt_diag_r[RES_W-1] ? root_ext[OUT_W-1:0] : axis_ext[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_dist_r <= dist_nxt;
    end
  end

  assign out_ch.valid        = vld_r[NSTG-1];
  assign out_ch.gap_distance = out_dist_r;

endmodule

// ===== rtl/rgd_checker.sv =====
// rgd_checker: port-level checks for rect_gap_distance, attached by bind.
// Depends on rgd_pkg.
module rgd_checker import rgd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_data
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty or draining output stage must let input in.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output stage is free");

  // A pending result stays until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  // A pending result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind rect_gap_distance rgd_checker u_rgd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.gap_distance)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for rect_gap_distance, one rectangle pair in and
// one gap distance out per transfer. Depends on rgd_pkg, rgd_in_if, rgd_out_if
// and the rect_gap_distance RTL.
module tb_top;
  import rgd_pkg::*;

  localparam int CW           = 13;             // coordinate width under test
  localparam int COORD_MAX    = (1 << CW) - 1;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 2 * (CW + 7);   // twice the pipeline depth
  localparam int QUIET_LIMIT  = 1000;           // cycles without any transfer
  localparam int HOLD_CYCLES  = 80;             // long output hold-off
  localparam int PHASE_PAIRS  = 200;            // random pairs per idle mix

  typedef struct packed {
    logic [CW-1:0] a_left;
    logic [CW-1:0] a_low;
    logic [CW-1:0] a_width;
    logic [CW-1:0] a_height;
    logic [CW-1:0] b_left;
    logic [CW-1:0] b_low;
    logic [CW-1:0] b_width;
    logic [CW-1:0] b_height;
  } rect_pair_t;

  // Distance predictor plus the queue of distances still owed by the block.
  class gap_scoreboard;
    logic [OUT_W-1:0] expected_q[$];
    int unsigned      pairs_noted;
    int unsigned      results_checked;
    int unsigned      mismatches;

    static function logic [CW:0] span(logic [CW:0] p, logic [CW:0] q);
      return (p > q) ? p - q : q - p;
    endfunction

    // floor(sqrt(dx^2 + dy^2)), settling one root bit at a time from the top
    static function logic [OUT_W-1:0] corner_gap(logic [CW:0] dx, logic [CW:0] dy);
      longint unsigned sum;
      longint unsigned root;
      longint unsigned trial;
      sum  = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
      root = 0;
      for (int b = OUT_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= sum) root = trial;
      end
      return root[OUT_W-1:0];
    endfunction

    static function logic [OUT_W-1:0] gap_for(rect_pair_t p);
      logic [CW:0]      ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      sep_flags_t       sep;
      logic [OUT_W-1:0] d;
      // far edges are one bit wider, so they never wrap
      ax0 = {1'b0, p.a_left};
      ay0 = {1'b0, p.a_low};
      ax1 = ax0 + p.a_width;
      ay1 = ay0 + p.a_height;
      bx0 = {1'b0, p.b_left};
      by0 = {1'b0, p.b_low};
      bx1 = bx0 + p.b_width;
      by1 = by0 + p.b_height;
      sep.left  = bx1 < ax0;
      sep.right = ax1 < bx0;
      sep.below = by1 < ay0;
      sep.above = ay1 < by0;
      // diagonal pairs first, in fixed priority; then single axes
      if (sep.above && sep.left)       d = corner_gap(span(ax0, bx1), span(ay1, by0));
      else if (sep.left && sep.below)  d = corner_gap(span(ax0, bx1), span(ay0, by1));
      else if (sep.below && sep.right) d = corner_gap(span(ax1, bx0), span(ay0, by1));
      else if (sep.right && sep.above) d = corner_gap(span(ax1, bx0), span(ay1, by0));
      else if (sep.left)               d = OUT_W'(ax0 - bx1);
      else if (sep.right)              d = OUT_W'(bx0 - ax1);
      else if (sep.below)              d = OUT_W'(ay0 - by1);
      else if (sep.above)              d = OUT_W'(by0 - ay1);
      else                             d = '0;   // overlap or touching
      return d;
    endfunction

    function void note_pair(rect_pair_t p);
      expected_q.insert(expected_q.size(), gap_for(p));
      pairs_noted++;
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("gap_distance %0d arrived with no pair pending", got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("gap_distance mismatch: expected %0d, got %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rgd_in_if #(.COORD_BITS(CW)) in_ch ();
  rgd_out_if                   out_ch ();

  rect_gap_distance #(.COORD_BITS(CW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gap_scoreboard sb = new();

  // idle mix shared by the sender task and the result sink
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 54;
  bit          hold_req;         // asks the sink for one long hold-off
  int unsigned random_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitors: sample at the rising edge, before any of this edge's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_pair('{in_ch.a_left, in_ch.a_low, in_ch.a_width, in_ch.a_height,
                     in_ch.b_left, in_ch.b_low, in_ch.b_width, in_ch.b_height});
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.gap_distance);
  end

  // Result sink: random stalls, plus a counted hold-off long enough to fill the
  // pipeline and push back on the input side.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("rect_gap_distance test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the pair until the transfer.
  // Called at a rising edge; returns at the edge of the transfer.
  // ---------------------------------------------------------------------------
  task automatic send_pair(input rect_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.a_left   <= p.a_left;
    in_ch.a_low    <= p.a_low;
    in_ch.a_width  <= p.a_width;
    in_ch.a_height <= p.a_height;
    in_ch.b_left   <= p.b_left;
    in_ch.b_low    <= p.b_low;
    in_ch.b_width  <= p.b_width;
    in_ch.b_height <= p.b_height;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic rect_pair_t make_pair(int al, int alo, int aw, int ah,
                                           int bl, int blo, int bw, int bh);
    rect_pair_t p;
    p = '{CW'(al), CW'(alo), CW'(aw), CW'(ah), CW'(bl), CW'(blo), CW'(bw), CW'(bh)};
    return p;
  endfunction

  // B origin on one axis: before, after or overlapping A, with gaps of 0
  // (touching), 1, 2 or wider so edge compares get hit exactly.
  function automatic logic [CW-1:0] place_near(int a_org, int a_ext, int b_ext);
    int gap;
    int pos;
    case ($urandom_range(0, 3))
      0:       gap = 0;
      1:       gap = 1;
      2:       gap = 2;
      default: gap = $urandom_range(3, 400);
    endcase
    case ($urandom_range(0, 2))
      0:       pos = a_org - b_ext - gap;
      1:       pos = a_org + a_ext + gap;
      default: pos = $urandom_range(a_org - b_ext, a_org + a_ext);
    endcase
    return CW'(pos);
  endfunction

  // Mostly pairs placed near each other (separations and touching edges),
  // some with small boxes anywhere, some fully uniform over all bits.
  function automatic rect_pair_t random_pair();
    rect_pair_t  p;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      p = make_pair($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    end else if (kind < 4) begin
      p = make_pair($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                    $urandom_range(0, 255), $urandom_range(0, 255));
    end else begin
      p.a_left   = CW'($urandom_range(1000, 7000));
      p.a_low    = CW'($urandom_range(1000, 7000));
      p.a_width  = CW'($urandom_range(0, 500));
      p.a_height = CW'($urandom_range(0, 500));
      p.b_width  = CW'($urandom_range(0, 500));
      p.b_height = CW'($urandom_range(0, 500));
      p.b_left   = place_near(int'(p.a_left), int'(p.a_width), int'(p.b_width));
      p.b_low    = place_near(int'(p.a_low), int'(p.a_height), int'(p.b_height));
    end
    return p;
  endfunction

  task automatic run_directed();
    // zero and full-scale fields, both overlapping
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // far corner of A exactly on B's origin: touching
    send_pair(make_pair(0, 0, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // four diagonal quadrants around A at (4000,4000)
    send_pair(make_pair(4000, 4000, 100, 100, 1000, 6000, 200, 300));   // above-left
    send_pair(make_pair(4000, 4000, 100, 100, 1000, 1000, 200, 300));   // left-below
    send_pair(make_pair(4000, 4000, 100, 100, 6000, 1000, 200, 300));   // below-right
    send_pair(make_pair(4000, 4000, 100, 100, 6000, 6000, 200, 300));   // right-above
    // single-axis gaps
    send_pair(make_pair(4000, 4000, 100, 100, 1000, 4050, 200, 10));    // left
    send_pair(make_pair(4000, 4000, 100, 100, 6000, 4050, 200, 10));    // right
    send_pair(make_pair(4000, 4000, 100, 100, 4050, 1000, 10, 200));    // below
    send_pair(make_pair(4000, 4000, 100, 100, 4050, 6000, 10, 200));    // above
    // point rectangles at opposite corners of the space: largest distances
    send_pair(make_pair(COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 0, COORD_MAX, COORD_MAX, 0, 0));
    send_pair(make_pair(0, COORD_MAX, 0, 0, COORD_MAX, 0, 0, 0));
    send_pair(make_pair(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 0, 0));
    // gap of one versus touching edge on x, then gaps of 11 and 10 above A
    send_pair(make_pair(100, 100, 10, 10, 89, 100, 10, 10));
    send_pair(make_pair(100, 100, 10, 10, 90, 100, 10, 10));
    send_pair(make_pair(100, 100, 10, 10, 100, 121, 10, 10));
    send_pair(make_pair(100, 100, 10, 10, 100, 120, 10, 10));
    // widest axis gap, full-height boxes
    send_pair(make_pair(COORD_MAX, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX));
    // exact and inexact roots: 3-4-5 and 1-1
    send_pair(make_pair(10, 10, 0, 0, 13, 14, 0, 0));
    send_pair(make_pair(10, 10, 0, 0, 11, 11, 0, 0));
    // alternating bit patterns
    send_pair(make_pair('h1555, 'h0AAA, 'h0AAA, 'h1555, 'h0AAA, 'h1555, 'h1555, 'h0AAA));
    send_pair(make_pair('h0AAA, 'h1555, 'h1555, 'h0AAA, 'h1555, 'h0AAA, 'h0AAA, 'h1555));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.a_left   <= '0;
    in_ch.a_low    <= '0;
    in_ch.a_width  <= '0;
    in_ch.a_height <= '0;
    in_ch.b_left   <= '0;
    in_ch.b_low    <= '0;
    in_ch.b_width  <= '0;
    in_ch.b_height <= '0;
    hold_req        = 1'b0;
    random_sent     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // idle mixes: receiver-heavy, sender-heavy, then none (with the hold-off)
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 31; recv_idle_pct = 54; end
        1:       begin send_idle_pct = 54; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  hold_req = 1'b1; end
      endcase
      repeat (PHASE_PAIRS) begin
        send_pair(random_pair());
        random_sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d rectangle pairs (%0d random) and %0d distances: corners, edges,",
             sb.pairs_noted, random_sent, sb.results_checked);
    $display("touching boxes, three idle mixes and one long output hold-off; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("rect_gap_distance test passed");
    end else begin
      $display("rect_gap_distance test failed");
    end
    $finish;
  end

endmodule
